@@ rtl/assert_macros.svh @@
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

@@ rtl/htce_pkg.sv @@
// Package with the types and constants of the Huffman tree code encoder.
`timescale 1ns / 1ps
`default_nettype none
package htce_pkg;

	localparam int LEAVES = 32;
	localparam int MAX_CODE = 31;

	localparam int NODE_W = 6;
	localparam int SYM_W = 8;
	localparam int CODE_W = 31;
	localparam int LEN_W = 5;
	localparam int NODE_COUNT = 1 << NODE_W;
	localparam int LEAF_AW = (LEAVES > 1) ? $clog2(LEAVES) : 1;
	localparam int SEARCH_LEAVES = (LEAVES < NODE_COUNT - 1) ? LEAVES : NODE_COUNT - 1;
	localparam int STEP_CAP = (MAX_CODE < CODE_W) ? MAX_CODE : CODE_W;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_ENCODE = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [NODE_W-1:0] node_index;
		logic [NODE_W-1:0] parent_index;
		logic [NODE_W-1:0] left_child_index;
		logic [SYM_W-1:0]  symbol;
	} cmd_item_t;

	typedef struct packed {
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_length;
		logic              symbol_known;
		logic              bad_tree;
	} code_item_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_CLIMB  = 4'b0100,
		ST_DONE   = 4'b1000
	} enc_state_t;

endpackage
`default_nettype wire

@@ rtl/huffman_tree_code_encoder_core.sv @@
// Encoder: leaf search and parent climb over the code tree tables held in memories.
// An encode request runs the leaf search, then the parent climb, and then hands over the result.
// A load request gives no result, and the next request follows at once.
// One encode request at a time: throughput is set by the search and climb sequencer,
// which reads one leaf symbol, or one parent and left-child entry pair, per cycle.
// Reset clears the sequencer and the output valid; the tree tables are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module huffman_tree_code_encoder_core
	import htce_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	output logic            cmd_ready,
	input  wire cmd_item_t  cmd_data,
	output logic            code_valid,
	input  wire logic       code_ready,
	output code_item_t      code_data
);

	localparam logic [LEAF_AW-1:0] LAST_LEAF = LEAF_AW'(SEARCH_LEAVES - 1);

	logic [NODE_W-1:0] parent_mem [NODE_COUNT];
	logic [NODE_W-1:0] left_mem [NODE_COUNT];
	logic [SYM_W-1:0]  leaf_mem [LEAVES];

	enc_state_t        state_q;
	logic              out_valid_q;
	code_item_t        out_q;
	code_item_t        res_q;

	logic [SYM_W-1:0]   sym_q;
	logic [LEAF_AW-1:0] idx_q;
	logic               iss_done_q;
	logic               cmp_vld_q;
	logic [LEAF_AW-1:0] cmp_idx_q;
	logic [SYM_W-1:0]   leaf_rd_q;
	logic [NODE_W-1:0]  par_rd_q;
	logic [NODE_W-1:0]  lc_rd_q;
	logic [NODE_W-1:0]  cur_q;
	logic [NODE_W-1:0]  prev_q;
	logic               pend_q;
	logic [LEN_W-1:0]   len_q;
	logic [CODE_W-1:0]  code_q;

	logic               cmd_take;
	logic               load_take;
	logic               enc_take;
	logic               leaf_we;
	logic [LEAF_AW-1:0] leaf_wa;
	logic               match;
	logic               found;
	logic               miss;
	logic [NODE_W-1:0]  found_node;
	logic [NODE_W-1:0]  par_ra;
	logic [LEN_W-1:0]   len_eff;
	logic [CODE_W-1:0]  code_eff;
	logic               climb_end;
	logic               climb_bad;
	logic               out_free;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_take = cmd_valid && cmd_ready;
	assign load_take = cmd_take && (cmd_data.mode == MODE_LOAD);
	assign enc_take = cmd_take && (cmd_data.mode == MODE_ENCODE);
	assign leaf_we = load_take && (cmd_data.node_index != '0)
		&& (int'(cmd_data.node_index) <= LEAVES);
	assign leaf_wa = LEAF_AW'(NODE_W'(cmd_data.node_index - NODE_W'(1)));

	assign match = (leaf_rd_q == sym_q);
	assign found = (state_q == ST_SEARCH) && cmp_vld_q && match;
	assign miss = (state_q == ST_SEARCH) && cmp_vld_q && !match && (cmp_idx_q == LAST_LEAF);
	assign found_node = NODE_W'(cmp_idx_q) + NODE_W'(1);
	assign par_ra = (state_q == ST_SEARCH) ? found_node : par_rd_q;

	always_comb begin
		len_eff = len_q + LEN_W'(pend_q);
		code_eff = code_q;
		if (pend_q && (lc_rd_q != prev_q)) begin
			code_eff = code_q | (CODE_W'(1) << len_q);
		end
	end

	assign climb_end = (state_q == ST_CLIMB) && (par_rd_q == '0);
	assign climb_bad = (state_q == ST_CLIMB) && (par_rd_q != '0)
		&& (len_eff >= LEN_W'(STEP_CAP));
	assign out_free = !out_valid_q || code_ready;

	always_ff @(posedge clk) begin
		if (load_take) begin
			parent_mem[cmd_data.node_index] <= cmd_data.parent_index;
			left_mem[cmd_data.node_index] <= cmd_data.left_child_index;
		end
		par_rd_q <= parent_mem[par_ra];
		lc_rd_q <= left_mem[par_rd_q];
	end

	always_ff @(posedge clk) begin
		if (leaf_we) begin
			leaf_mem[leaf_wa] <= cmd_data.symbol;
		end
		leaf_rd_q <= leaf_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			iss_done_q <= 1'b0;
			cmp_vld_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (code_valid && code_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (enc_take) begin
						state_q <= ST_SEARCH;
						iss_done_q <= 1'b0;
						cmp_vld_q <= 1'b0;
					end
				end
				ST_SEARCH: begin
					cmp_vld_q <= !iss_done_q;
					if (!iss_done_q) begin
						iss_done_q <= (idx_q == LAST_LEAF);
					end
					if (found) begin
						state_q <= ST_CLIMB;
						pend_q <= 1'b0;
					end else if (miss) begin
						state_q <= ST_DONE;
					end
				end
				ST_CLIMB: begin
					if (climb_end || climb_bad) begin
						state_q <= ST_DONE;
					end
					pend_q <= 1'b1;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (enc_take) begin
			sym_q <= cmd_data.symbol;
			idx_q <= '0;
		end
		if ((state_q == ST_SEARCH) && !iss_done_q) begin
			cmp_idx_q <= idx_q;
			idx_q <= idx_q + LEAF_AW'(1);
		end
		if (found) begin
			cur_q <= found_node;
			len_q <= '0;
			code_q <= '0;
		end
		if (state_q == ST_CLIMB) begin
			prev_q <= cur_q;
			cur_q <= par_rd_q;
			len_q <= len_eff;
			code_q <= code_eff;
		end
		if (miss) begin
			res_q <= '0;
		end
		if (climb_end) begin
			res_q.code_bits <= code_eff;
			res_q.code_length <= len_eff;
			res_q.symbol_known <= 1'b1;
			res_q.bad_tree <= 1'b0;
		end
		if (climb_bad) begin
			res_q.code_bits <= '0;
			res_q.code_length <= '0;
			res_q.symbol_known <= 1'b1;
			res_q.bad_tree <= 1'b1;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_q <= res_q;
		end
	end

	assign code_valid = out_valid_q;
	assign code_data = out_q;

	`ASSERT_NEXT(a_enc_starts_search, clk, arst_n, enc_take, state_q == ST_SEARCH)
	`ASSERT_IMPLIES(a_climb_within_cap, clk, arst_n, state_q == ST_CLIMB, len_q <= LEN_W'(STEP_CAP))
	`ASSERT_IMPLIES(a_bad_result_empty, clk, arst_n, state_q == ST_DONE && res_q.bad_tree, res_q.code_length == '0 && res_q.symbol_known)
	`ASSERT_NEXT(a_done_waits_for_slot, clk, arst_n, state_q == ST_DONE && !out_free, state_q == ST_DONE)
	`ASSERT_IMPLIES(a_known_only_after_match, clk, arst_n, state_q == ST_DONE && !res_q.symbol_known, res_q.code_length == '0 && !res_q.bad_tree)

endmodule
`default_nettype wire
